// File: sv/kli_pkg.sv
// ----------------------------------------------------------------------------
// kli_pkg
// Shared types, codes and defaults for the keyframe interpolator.
// ----------------------------------------------------------------------------
package kli_pkg;

  // Track field reaches at most this many tracks
  localparam int unsigned TRACK_FIELD_SPAN = 16;
  localparam int unsigned DEF_NUM_TRACKS   = 16;
  localparam int unsigned DEF_MAX_KEYS     = 32;

  // Quotient bits of the interpolation divide (result never exceeds 16 bits)
  localparam int unsigned QUO_BITS = 16;

  // Input modes
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_PLAY = 2'd2;
  localparam logic [1:0] MODE_SEEK = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_DURATION = 2'd1;
  localparam logic [1:0] REG_LOOP     = 2'd2;

  localparam logic [31:0] DURATION_RESET = 32'h0001_0000;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         track;
    logic [4:0]         slot;
    logic [31:0]        time_value;
    logic signed [15:0] key_angle;
    logic               play;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         out_track;
    logic signed [15:0] angle;
    logic               last;
  } out_item_t;

  typedef enum logic [1:0] {
    RA_FIRST,
    RA_LAST,
    RA_SCAN
  } raddr_sel_e;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_FIRST,
    RES_LAST,
    RES_LERP
  } res_sel_e;

  typedef struct packed {
    logic       accept;
    logic       trk_clr;
    logic       trk_inc;
    logic       rd_en;
    raddr_sel_e ra_sel;
    logic       cap_first;
    logic       cap_last;
    logic       j_clr;
    logic       j_inc;
    logic       scan_cap;
    logic       pair_cap;
    logic       mul;
    logic       div_init;
    logic       div_step;
    res_sel_e   res_sel;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic emit_req;
    logic trk_nonempty;
    logic no_more;
    logic le_first;
    logic ge_last;
    logic pair_hit;
    logic scan_end;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// File: sv/keyframe_linear_interpolator_unit.sv
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_unit
// Keyframe tables per track and a playback clock with linear interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o, in_data_i) takes one command beat:
//   key load, tick, play/stop or seek. Loads, play and ticks that do nothing
//   never stall and emit nothing. Tick (when enabled and playing),
//   stop and seek emit one output beat per non-empty track, in ascending
//   track order, with last set on the final beat. An emitting command holds
//   in_stall_o high until its final beat sits in the output register.
//   Per track: an empty track is skipped, a clock outside the key range takes
//   the first or last key angle, else serial key scan reads (one a cycle,
//   from 2 up to the key count) find the pair for the bit-serial divider.
//   Configuration (cfg_valid_i / cfg_ready_o) is always ready: 0 enable,
//   1 duration, 2 loop mode. The user must see that it is written only
//   while idle; the block itself has no check for it.
//   Reset clears all tracks to empty, the clock to zero and stops playback.
//   A stalled output beat holds; the block keeps computing the next track
//   and waits only when that result is ready too.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator_unit import kli_pkg::*; #(
  parameter int unsigned NUM_TRACKS = DEF_NUM_TRACKS,
  parameter int unsigned MAX_KEYS   = DEF_MAX_KEYS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  kli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  kli_dp #(
    .NUM_TRACKS (NUM_TRACKS),
    .MAX_KEYS   (MAX_KEYS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// File: sv/kli_ram.sv
// ----------------------------------------------------------------------------
// kli_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module kli_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/kli_ctrl.sv
// ----------------------------------------------------------------------------
// kli_ctrl
// Sequencer: walks the tracks, drives key reads, scan, divide and output.
// ----------------------------------------------------------------------------
module kli_ctrl import kli_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRK,
    S_FIRST,
    S_LAST,
    S_CHK,
    S_SCAN,
    S_MUL,
    S_DINI,
    S_DIV,
    S_RES,
    S_OUT
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.ra_sel  = RA_FIRST;
    cmd_o.res_sel = RES_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.emit_req) begin
            cmd_o.trk_clr = 1'b1;
            state_d       = S_TRK;
          end
        end
      end
      S_TRK: begin
        if (status_i.trk_nonempty) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.ra_sel = RA_FIRST;
          state_d      = S_FIRST;
        end else if (status_i.no_more) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.trk_inc = 1'b1;
        end
      end
      S_FIRST: begin
        cmd_o.cap_first = 1'b1;
        cmd_o.j_clr     = 1'b1;
        cmd_o.rd_en     = 1'b1;
        cmd_o.ra_sel    = RA_LAST;
        state_d         = S_LAST;
      end
      S_LAST: begin
        cmd_o.cap_last = 1'b1;
        state_d        = S_CHK;
      end
      S_CHK: begin
        if (status_i.le_first) begin
          cmd_o.res_sel = RES_FIRST;
          state_d       = S_OUT;
        end else if (status_i.ge_last) begin
          cmd_o.res_sel = RES_LAST;
          state_d       = S_OUT;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.ra_sel = RA_SCAN;
          cmd_o.j_inc  = 1'b1;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_cap = 1'b1;
        if (status_i.pair_hit || status_i.scan_end) begin
          cmd_o.pair_cap = 1'b1;
          state_d        = S_MUL;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.ra_sel = RA_SCAN;
          cmd_o.j_inc  = 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DINI;
      end
      S_DINI: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = S_RES;
        end
      end
      S_RES: begin
        cmd_o.res_sel = RES_LERP;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (status_i.no_more) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.trk_inc = 1'b1;
            state_d       = S_TRK;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/kli_dp.sv
// ----------------------------------------------------------------------------
// kli_dp
// Datapath: config, playback clock, key store, scan compare, divider, output.
// ----------------------------------------------------------------------------
module kli_dp import kli_pkg::*; #(
  parameter int unsigned NUM_TRACKS = DEF_NUM_TRACKS,
  parameter int unsigned MAX_KEYS   = DEF_MAX_KEYS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  in_item_t    in_data_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output out_item_t   out_data_o,
  input  cmd_t        cmd_i,
  output status_t     status_o
);

  localparam int unsigned NTE   = (NUM_TRACKS < TRACK_FIELD_SPAN) ? NUM_TRACKS
                                                                  : TRACK_FIELD_SPAN;
  localparam int unsigned TW    = (NTE > 1) ? $clog2(NTE) : 1;
  localparam int unsigned KW    = $clog2(MAX_KEYS);
  localparam int unsigned CW    = $clog2(MAX_KEYS + 1);
  localparam int unsigned DEPTH = NTE * MAX_KEYS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DCW   = $clog2(QUO_BITS);
  localparam int unsigned NW    = 48 + 2;

  // configuration registers
  logic        enable_q, loop_q;
  logic [31:0] duration_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      loop_q     <= 1'b0;
      duration_q <= DURATION_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ENABLE:   enable_q   <= cfg_data_i[0];
        REG_DURATION: duration_q <= cfg_data_i;
        REG_LOOP:     loop_q     <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  // playback clock update
  logic [31:0] cur_q, cur_d;
  logic        playing_q, playing_d;
  logic [32:0] tick_sum;
  logic [31:0] tick_t;
  logic        emit_req;
  logic        load_ok;

  assign tick_sum = {1'b0, cur_q} + {1'b0, in_data_i.time_value};
  assign tick_t   = tick_sum[32] ? 32'hFFFF_FFFF : tick_sum[31:0];
  assign load_ok  = (32'(in_data_i.track) < NTE) && (32'(in_data_i.slot) < MAX_KEYS);

  always_comb begin
    cur_d     = cur_q;
    playing_d = playing_q;
    emit_req  = 1'b0;
    case (in_data_i.mode)
      MODE_TICK: begin
        if (enable_q && playing_q) begin
          emit_req = 1'b1;
          cur_d    = tick_t;
          if (tick_t > duration_q) begin
            if (loop_q) begin
              cur_d = '0;
            end else begin
              cur_d     = duration_q;
              playing_d = 1'b0;
            end
          end
        end
      end
      MODE_PLAY: begin
        if (in_data_i.play) begin
          playing_d = 1'b1;
        end else begin
          playing_d = 1'b0;
          cur_d     = '0;
          emit_req  = 1'b1;
        end
      end
      MODE_SEEK: begin
        emit_req = 1'b1;
        cur_d    = (in_data_i.time_value > duration_q) ? duration_q
                                                        : in_data_i.time_value;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= '0;
      playing_q <= 1'b0;
    end else if (cmd_i.accept) begin
      cur_q     <= cur_d;
      playing_q <= playing_d;
    end
  end

  // key counts per track
  logic [CW-1:0] count_q [NTE];
  logic [NTE-1:0] nonempty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < NTE; t++) begin
        count_q[t] <= '0;
      end
    end else if (cmd_i.accept && in_data_i.mode == MODE_LOAD && load_ok) begin
      count_q[in_data_i.track[TW-1:0]] <= CW'(32'(in_data_i.slot) + 1);
    end
  end

  always_comb begin
    for (int t = 0; t < NTE; t++) begin
      nonempty[t] = (count_q[t] != '0);
    end
  end

  // track and scan counters
  logic [TW-1:0] tr_q;
  logic [CW-1:0] j_q;
  logic [CW-1:0] n_cur, n_m1;
  logic          more;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tr_q <= '0;
      j_q  <= '0;
    end else begin
      if (cmd_i.trk_clr) begin
        tr_q <= '0;
      end else if (cmd_i.trk_inc) begin
        tr_q <= tr_q + TW'(1);
      end
      if (cmd_i.j_clr) begin
        j_q <= '0;
      end else if (cmd_i.j_inc) begin
        j_q <= j_q + CW'(1);
      end
    end
  end

  assign n_cur = count_q[tr_q];
  assign n_m1  = n_cur - CW'(1);

  always_comb begin
    more = 1'b0;
    for (int t = 0; t < NTE; t++) begin
      if (t > 32'(tr_q) && nonempty[t]) begin
        more = 1'b1;
      end
    end
  end

  // key store
  logic [AW-1:0] waddr, raddr;
  logic [KW-1:0] ridx;
  logic [47:0]   rdata;
  logic [31:0]   rd_t;
  logic [15:0]   rd_v;

  assign waddr = AW'(32'(in_data_i.track) * MAX_KEYS + 32'(in_data_i.slot));

  always_comb begin
    case (cmd_i.ra_sel)
      RA_LAST: ridx = n_m1[KW-1:0];
      RA_SCAN: ridx = j_q[KW-1:0];
      default: ridx = '0;
    endcase
  end

  assign raddr = AW'(32'(tr_q) * MAX_KEYS + 32'(ridx));

  kli_ram #(
    .WIDTH (48),
    .DEPTH (DEPTH)
  ) u_keys (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && in_data_i.mode == MODE_LOAD && load_ok),
    .waddr_i (waddr),
    .wdata_i ({in_data_i.time_value, in_data_i.key_angle}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_t = rdata[47:16];
  assign rd_v = rdata[15:0];

  // key registers: first, last, previous in scan, selected pair
  logic [31:0] t0_q, tl_q, tp_q, t1_q, t2_q;
  logic [15:0] v0_q, vl_q, vp_q, v1_q, v2_q;
  logic        pair_hit;

  assign pair_hit = (j_q >= CW'(2)) && (tp_q <= cur_q) && (cur_q < rd_t);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_first) begin
      t0_q <= rd_t;
      v0_q <= rd_v;
    end
    if (cmd_i.cap_last) begin
      tl_q <= rd_t;
      vl_q <= rd_v;
    end
    if (cmd_i.scan_cap) begin
      tp_q <= rd_t;
      vp_q <= rd_v;
    end
    if (cmd_i.pair_cap) begin
      if (pair_hit) begin
        t1_q <= tp_q;
        v1_q <= vp_q;
        t2_q <= rd_t;
        v2_q <= rd_v;
      end else begin
        t1_q <= t0_q;
        v1_q <= v0_q;
        t2_q <= tl_q;
        v2_q <= vl_q;
      end
    end
  end

  // product and restoring divide: q = (2*|dv|*num + den) / (2*den)
  logic signed [16:0] dv;
  logic [15:0]        mag;
  logic               neg;
  logic [31:0]        num, den;
  logic [47:0]        prod_q;
  logic [NW-1:0]      nfull;
  logic [33:0]        rem_q, rshift, dd;
  logic [QUO_BITS-1:0] nb_q, quo_q;
  logic [DCW-1:0]     dcnt_q;
  logic               degen;

  assign dv    = 17'(signed'(v2_q)) - 17'(signed'(v1_q));
  assign neg   = dv[16];
  assign mag   = 16'(neg ? -dv : dv);
  assign num   = cur_q - t1_q;
  assign den   = t2_q - t1_q;
  assign nfull = {prod_q, 1'b0} + NW'(den);
  assign dd    = {1'b0, den, 1'b0};
  assign rshift = {rem_q[32:0], nb_q[QUO_BITS-1]};
  assign degen = (t2_q <= t1_q) || (cur_q < t1_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= 48'(mag) * 48'(num);
    end
    if (cmd_i.div_init) begin
      rem_q  <= 34'(nfull >> QUO_BITS);
      nb_q   <= nfull[QUO_BITS-1:0];
      quo_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rshift >= dd) begin
        rem_q <= rshift - dd;
        quo_q <= {quo_q[QUO_BITS-2:0], 1'b1};
      end else begin
        rem_q <= rshift;
        quo_q <= {quo_q[QUO_BITS-2:0], 1'b0};
      end
      nb_q   <= {nb_q[QUO_BITS-2:0], 1'b0};
      dcnt_q <= dcnt_q + DCW'(1);
    end
  end

  // result register
  logic [15:0] res_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.res_sel)
      RES_FIRST: res_q <= v0_q;
      RES_LAST:  res_q <= vl_q;
      RES_LERP:  res_q <= degen ? v1_q : (neg ? v1_q - quo_q : v1_q + quo_q);
      default:   ;
    endcase
  end

  // output beat register
  logic      out_valid_q;
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.out_track <= 4'(tr_q);
      out_q.angle     <= res_q;
      out_q.last      <= !more;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // status to sequencer
  assign status_o.emit_req     = emit_req;
  assign status_o.trk_nonempty = nonempty[tr_q];
  assign status_o.no_more      = !more;
  assign status_o.le_first     = (cur_q <= t0_q);
  assign status_o.ge_last      = (cur_q >= tl_q);
  assign status_o.pair_hit     = pair_hit;
  assign status_o.scan_end     = (j_q == n_cur);
  assign status_o.div_done     = (dcnt_q == DCW'(QUO_BITS - 1));
  assign status_o.out_free     = !out_valid_q || !out_stall_i;

endmodule

// File: sim/kli_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kli_checker
// Watches the configuration, command and angle channels of the keyframe
// interpolator, keeps its own copy of tables, clock and registers, queues
// the angles each accepted command should produce and compares every
// output beat against the oldest one.
// ----------------------------------------------------------------------------
module kli_checker import kli_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output logic        beat_seen_o
);

  logic [31:0]        tbl_time [DEF_NUM_TRACKS][DEF_MAX_KEYS];
  logic signed [15:0] tbl_angle[DEF_NUM_TRACKS][DEF_MAX_KEYS];
  int unsigned        tbl_count[DEF_NUM_TRACKS];
  logic [31:0]        clock_now;
  logic               running;
  logic               en_q;
  logic [31:0]        dur_q;
  logic               loop_q;
  out_item_t          angle_queue[$];

  assign pending_o = angle_queue.size();

  // Linear blend with rounding half away from zero
  function automatic logic signed [15:0] blend_angle(logic [31:0] t, logic [31:0] t1,
      logic signed [15:0] v1, logic [31:0] t2, logic signed [15:0] v2);
    longint diff;
    longint unsigned mag, num, den, q;
    if (t2 <= t1 || t < t1) return v1;
    num  = t - t1;
    den  = t2 - t1;
    diff = longint'(v2) - longint'(v1);
    mag  = diff < 0 ? -diff : diff;
    q    = (mag * num * 2 + den) / (den * 2);
    return diff < 0 ? v1 - 16'(q) : v1 + 16'(q);
  endfunction

  function automatic logic signed [15:0] angle_at(int tr, logic [31:0] t);
    int n;
    int a;
    int b;
    n = tbl_count[tr];
    a = 0;
    b = n - 1;
    if (t <= tbl_time[tr][0]) return tbl_angle[tr][0];
    if (t >= tbl_time[tr][n-1]) return tbl_angle[tr][n-1];
    for (int i = 0; i + 1 < n; i++) begin
      if (t >= tbl_time[tr][i] && t < tbl_time[tr][i+1]) begin
        a = i;
        b = i + 1;
        break;
      end
    end
    return blend_angle(t, tbl_time[tr][a], tbl_angle[tr][a], tbl_time[tr][b],
                       tbl_angle[tr][b]);
  endfunction

  task automatic queue_frame();
    out_item_t r;
    int k;
    k = 0;
    for (int tr = 0; tr < DEF_NUM_TRACKS; tr++) begin
      if (tbl_count[tr] != 0) begin
        r.out_track = 4'(tr);
        r.angle     = angle_at(tr, clock_now);
        r.last      = 1'b0;
        angle_queue = {angle_queue, r};
        k++;
      end
    end
    if (k > 0) angle_queue[angle_queue.size()-1].last = 1'b1;
  endtask

  task automatic apply_command(in_item_t c);
    logic [32:0] sum;
    logic [31:0] nt;
    case (c.mode)
      MODE_LOAD: begin
        tbl_time[c.track][c.slot]  = c.time_value;
        tbl_angle[c.track][c.slot] = c.key_angle;
        tbl_count[c.track]         = c.slot + 1;
      end
      MODE_TICK: begin
        if (en_q && running) begin
          sum = {1'b0, clock_now} + c.time_value;
          nt  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          if (nt > dur_q) begin
            if (loop_q) nt = '0;
            else begin
              nt      = dur_q;
              running = 1'b0;
            end
          end
          clock_now = nt;
          queue_frame();
        end
      end
      MODE_PLAY: begin
        if (c.play) running = 1'b1;
        else begin
          running   = 1'b0;
          clock_now = '0;
          queue_frame();
        end
      end
      default: begin
        clock_now = c.time_value > dur_q ? dur_q : c.time_value;
        queue_frame();
      end
    endcase
  endtask

  // Track every handshake on the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_beat;
    if (!rst_ni) begin
      for (int tr = 0; tr < DEF_NUM_TRACKS; tr++) tbl_count[tr] = 0;
      clock_now    = '0;
      running      = 1'b0;
      en_q         = 1'b0;
      dur_q        = DURATION_RESET;
      loop_q       = 1'b0;
      fail_count_o <= 0;
      beat_seen_o  <= 1'b0;
      angle_queue.delete();
    end else begin
      beat_seen_o <= (in_valid_i && !in_stall_i) || (out_valid_i && !out_stall_i) ||
                     (cfg_valid_i && cfg_ready_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ENABLE:   en_q   = cfg_data_i[0];
          REG_DURATION: dur_q  = cfg_data_i;
          REG_LOOP:     loop_q = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (angle_queue.size() == 0) begin
          $display("%0t: unexpected beat, actual track %0d angle %0d last %0b", $time,
                   out_data_i.out_track, out_data_i.angle, out_data_i.last);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_beat = angle_queue.pop_front();
          if (exp_beat != out_data_i) begin
            $display("%0t: mismatch, expected track %0d angle %0d last %0b, actual %0d %0d %0b",
                     $time, exp_beat.out_track, exp_beat.angle, exp_beat.last,
                     out_data_i.out_track, out_data_i.angle, out_data_i.last);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) apply_command(in_data_i);
    end
  end

endmodule

// File: sim/tb_keyframe_linear_interpolator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyframe_linear_interpolator_unit
// Drives key loads, ticks, play/stop and seeks into the interpolator under
// several duration and loop settings, with random gaps and output stalls
// and one long output hold-off; the checker scores the angle beats.
// ----------------------------------------------------------------------------
module tb_keyframe_linear_interpolator_unit import kli_pkg::*;;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;
  int          fail_count;
  int          pending;
  logic        beat_seen;
  logic        gaps_on;
  logic        hold_req;
  int          idle_cycles;
  int          key_fill[DEF_NUM_TRACKS];

  keyframe_linear_interpolator_unit DUT (.*);

  kli_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i, .out_valid_i(out_valid_o),
    .out_stall_i, .out_data_i(out_data_o), .fail_count_o(fail_count),
    .pending_o(pending), .beat_seen_o(beat_seen)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Receiver: random stall bursts, or a long hold-off on request
  initial begin
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (400) @(negedge clk_i);
        out_stall_i <= 1'b0;
        wait (!hold_req);
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 5);
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Count cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || beat_seen) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one command beat; valid stays up afterwards until the next gap or drain
  task automatic send_cmd(in_item_t c);
    int n;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (1000) @(negedge clk_i);
  endtask

  function automatic in_item_t make_cmd(logic [1:0] m, int tr, int sl, logic [31:0] tv,
                                        logic [15:0] ang, logic p);
    in_item_t c;
    c.mode       = m;
    c.track      = 4'(tr);
    c.slot       = 5'(sl);
    c.time_value = tv;
    c.key_angle  = ang;
    c.play       = p;
    return c;
  endfunction

  // Loads a non-decreasing key table; times start at zero or a random value
  task automatic load_track(int tr, int n, logic [31:0] step);
    logic [31:0] t;
    t = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(0, 32'h2_0000);
    for (int s = 0; s < n; s++) begin
      send_cmd(make_cmd(MODE_LOAD, tr, s, t, 16'($urandom), 1'b0));
      if ($urandom_range(0, 5) != 0) t = t + $urandom_range(0, step);
    end
    key_fill[tr] = n;
  endtask

  function automatic logic [31:0] rand_time();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return 32'd0;
      2: return $urandom;
      default: return $urandom_range(0, 32'h6_0000);
    endcase
  endfunction

  function automatic in_item_t rand_cmd();
    logic [1:0] m;
    int tr;
    m  = 2'($urandom_range(0, 3));
    tr = $urandom_range(0, DEF_NUM_TRACKS - 1);
    if (m == MODE_LOAD) begin
      // Only overwrite existing slots of a filled track, or reload slot 0
      if (key_fill[tr] == 0) key_fill[tr] = 1;
      else key_fill[tr] = $urandom_range(1, key_fill[tr]);
      return make_cmd(MODE_LOAD, tr, key_fill[tr] - 1, rand_time(), 16'($urandom), 1'b0);
    end
    if (m == MODE_TICK && $urandom_range(0, 1) == 0)
      return make_cmd(MODE_TICK, tr, $urandom, $urandom_range(0, 32'h8000), 16'($urandom), 1'b0);
    return make_cmd(m, tr, $urandom, rand_time(), 16'($urandom),
                    $urandom_range(0, 2) != 0);
  endfunction

  initial begin
    logic [31:0] dur_set[4];
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_ENABLE;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    gaps_on     = 1'b0;
    hold_req    = 1'b0;
    for (int tr = 0; tr < DEF_NUM_TRACKS; tr++) key_fill[tr] = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty frame, disabled tick, then tables and edge times
    send_cmd(make_cmd(MODE_SEEK, 0, 0, 32'd5, 16'd0, 1'b0));
    send_cmd(make_cmd(MODE_PLAY, 0, 0, 0, 16'd0, 1'b1));
    send_cmd(make_cmd(MODE_TICK, 0, 0, 32'h100, 16'd0, 1'b0));
    send_cmd(make_cmd(MODE_LOAD, 0, 0, 32'h0, 16'sh7FFF, 1'b0));
    send_cmd(make_cmd(MODE_LOAD, 0, 1, 32'h1_0000, 16'sh8000, 1'b0));
    send_cmd(make_cmd(MODE_LOAD, 15, 0, 32'h8000, 16'sh1234, 1'b0));
    send_cmd(make_cmd(MODE_LOAD, 15, 1, 32'h8000, 16'shF00D, 1'b0));
    send_cmd(make_cmd(MODE_LOAD, 15, 2, 32'hC000, 16'sh0100, 1'b0));
    send_cmd(make_cmd(MODE_LOAD, 7, 31, 32'hFFFF_FFFF, 16'sh0, 1'b0));
    send_cmd(make_cmd(MODE_LOAD, 7, 0, 32'h4000, 16'sh4000, 1'b0));
    key_fill[0] = 2;  key_fill[15] = 3;  key_fill[7] = 1;
    send_cmd(make_cmd(MODE_SEEK, 0, 0, 32'h8000, 16'd0, 1'b0));
    send_cmd(make_cmd(MODE_SEEK, 0, 0, 32'hFFFF_FFFF, 16'd0, 1'b0));
    send_cmd(make_cmd(MODE_SEEK, 0, 0, 32'hA000, 16'd0, 1'b0));
    drain();
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_DURATION, 32'hFFFF_FFFF);
    send_cmd(make_cmd(MODE_TICK, 0, 0, 32'h2000, 16'd0, 1'b0));
    send_cmd(make_cmd(MODE_TICK, 0, 0, 32'hFFFF_FFFF, 16'd0, 1'b0));
    send_cmd(make_cmd(MODE_PLAY, 0, 0, 0, 16'd0, 1'b0));
    drain();

    // Random phases across duration and loop settings
    dur_set = '{32'd0, 32'h1_0000, 32'h4_0000, 32'hFFFF_FFFF};
    gaps_on = 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_ENABLE, 32'($urandom_range(0, 4) != 0));
      write_reg(REG_DURATION, ph < 4 ? dur_set[ph] : $urandom_range(0, 32'h8_0000));
      write_reg(REG_LOOP, 32'(ph % 2));
      for (int tr = 0; tr < DEF_NUM_TRACKS; tr++)
        if ($urandom_range(0, 7) == 0)
          load_track(tr, $urandom_range(0, 4) == 0 ? 32 : $urandom_range(1, 6), 32'h8000);
      if (ph == 2) hold_req = 1'b1;
      send_cmd(make_cmd(MODE_PLAY, 0, 0, 0, 16'd0, 1'b1));
      for (int k = 0; k < 20; k++) begin
        if (ph == 5 && k == 12) gaps_on = 1'b0;
        send_cmd(rand_cmd());
      end
      hold_req = 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
